// File: rtl/ufbs_pkg.sv
// Package for the UART fractional baud search: types, constants and fraction table.
`default_nettype none
package ufbs_pkg;
    localparam int unsigned ClkW   = 29;
    localparam int unsigned BaudW  = 22;
    localparam int unsigned DivW   = 23;
    localparam int unsigned FracW  = 8;
    localparam int unsigned TableEntries = 72;
    localparam int unsigned IdxW   = 7;
    // den = 64*baud*div <= 64*clk < 2^35; den*1933 < 2^46
    localparam int unsigned DenW   = 35;
    localparam int unsigned ProdW  = 47;
    localparam int unsigned QuoW   = 29;
    localparam logic [ClkW-1:0] ClkReset = 29'd72000000;
    localparam logic [FracW-1:0] FracDefault = 8'h10;
    localparam logic [10:0] MilliLow  = 11'd1100;
    localparam logic [10:0] MilliHigh = 11'd1900;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV64, S_CHK64, S_DIV96, S_CHK96, S_MULLO, S_MULHI,
        S_CMP, S_SCAN, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DSEL_64, DSEL_96
    } t_dsel;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture baud
        logic div_start;  // start divider
        t_dsel dsel;
        logic save64;     // latch quotient of clk/(64 baud) as result
        logic save96;     // latch quotient of clk/(96 baud)
        logic mk_den;     // form den
        logic mul_lo;     // form den*1100
        logic mul_hi;     // form den*1900
        logic scan_clr;
        logic scan_step;
        logic out_push;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic baud_zero;
        logic div_busy;
        logic rem_zero;
        logic quo_zero;
        logic in_range;
        logic scan_hit;
        logic scan_end;
    } t_sts;

    function automatic logic [18:0] frac_entry(input logic [IdxW-1:0] idx);
        logic [18:0] e;
        case (idx)
            7'd0: e = {11'd1000,4'd0,4'd1};  7'd1: e = {11'd1067,4'd1,4'd15};
            7'd2: e = {11'd1071,4'd1,4'd14}; 7'd3: e = {11'd1077,4'd1,4'd13};
            7'd4: e = {11'd1083,4'd1,4'd12}; 7'd5: e = {11'd1091,4'd1,4'd11};
            7'd6: e = {11'd1100,4'd1,4'd10}; 7'd7: e = {11'd1111,4'd1,4'd9};
            7'd8: e = {11'd1125,4'd1,4'd8};  7'd9: e = {11'd1133,4'd2,4'd15};
            7'd10: e = {11'd1143,4'd1,4'd7}; 7'd11: e = {11'd1154,4'd2,4'd13};
            7'd12: e = {11'd1167,4'd1,4'd6}; 7'd13: e = {11'd1182,4'd2,4'd11};
            7'd14: e = {11'd1200,4'd1,4'd5}; 7'd15: e = {11'd1214,4'd3,4'd14};
            7'd16: e = {11'd1222,4'd2,4'd9}; 7'd17: e = {11'd1231,4'd3,4'd13};
            7'd18: e = {11'd1250,4'd1,4'd4}; 7'd19: e = {11'd1267,4'd4,4'd15};
            7'd20: e = {11'd1273,4'd3,4'd11}; 7'd21: e = {11'd1286,4'd2,4'd7};
            7'd22: e = {11'd1300,4'd3,4'd10}; 7'd23: e = {11'd1308,4'd4,4'd13};
            7'd24: e = {11'd1333,4'd1,4'd3}; 7'd25: e = {11'd1357,4'd5,4'd14};
            7'd26: e = {11'd1364,4'd4,4'd11}; 7'd27: e = {11'd1375,4'd3,4'd8};
            7'd28: e = {11'd1385,4'd5,4'd13}; 7'd29: e = {11'd1400,4'd2,4'd5};
            7'd30: e = {11'd1417,4'd5,4'd12}; 7'd31: e = {11'd1429,4'd3,4'd7};
            7'd32: e = {11'd1444,4'd4,4'd9}; 7'd33: e = {11'd1455,4'd5,4'd11};
            7'd34: e = {11'd1462,4'd6,4'd13}; 7'd35: e = {11'd1467,4'd7,4'd15};
            7'd36: e = {11'd1500,4'd1,4'd2}; 7'd37: e = {11'd1533,4'd8,4'd15};
            7'd38: e = {11'd1538,4'd7,4'd13}; 7'd39: e = {11'd1545,4'd6,4'd11};
            7'd40: e = {11'd1556,4'd5,4'd9}; 7'd41: e = {11'd1571,4'd4,4'd7};
            7'd42: e = {11'd1583,4'd7,4'd12}; 7'd43: e = {11'd1600,4'd3,4'd5};
            7'd44: e = {11'd1615,4'd8,4'd13}; 7'd45: e = {11'd1625,4'd5,4'd8};
            7'd46: e = {11'd1636,4'd7,4'd11}; 7'd47: e = {11'd1643,4'd9,4'd14};
            7'd48: e = {11'd1667,4'd2,4'd3}; 7'd49: e = {11'd1692,4'd9,4'd13};
            7'd50: e = {11'd1700,4'd7,4'd10}; 7'd51: e = {11'd1714,4'd5,4'd7};
            7'd52: e = {11'd1727,4'd8,4'd11}; 7'd53: e = {11'd1733,4'd11,4'd15};
            7'd54: e = {11'd1750,4'd3,4'd4}; 7'd55: e = {11'd1769,4'd10,4'd13};
            7'd56: e = {11'd1778,4'd7,4'd9}; 7'd57: e = {11'd1786,4'd11,4'd14};
            7'd58: e = {11'd1800,4'd4,4'd5}; 7'd59: e = {11'd1818,4'd9,4'd11};
            7'd60: e = {11'd1833,4'd5,4'd6}; 7'd61: e = {11'd1846,4'd11,4'd13};
            7'd62: e = {11'd1857,4'd6,4'd7}; 7'd63: e = {11'd1867,4'd13,4'd15};
            7'd64: e = {11'd1875,4'd7,4'd8}; 7'd65: e = {11'd1889,4'd8,4'd9};
            7'd66: e = {11'd1900,4'd9,4'd10}; 7'd67: e = {11'd1909,4'd10,4'd11};
            7'd68: e = {11'd1917,4'd11,4'd12}; 7'd69: e = {11'd1923,4'd12,4'd13};
            7'd70: e = {11'd1929,4'd13,4'd14}; 7'd71: e = {11'd1933,4'd14,4'd15};
            default: e = {11'd0,4'd0,4'd1};
        endcase
        return e;
    endfunction
endpackage
`default_nettype wire

// File: rtl/uart_fractional_baud_search_top.sv
// Top level of the UART fractional baud search.
`default_nettype none
// Each request carries a wanted baud rate and yields one result with the divisor
// latch value and the packed fractional byte (add in bits 3..0, multiplier in
// 7..4). A request whose clock divides evenly needs one bit-serial division;
// any other needs two bit-serial divisions and, at most, the multiply and compare
// steps and a scan of up to 67 table entries at one entry a cycle; a zero baud
// rate skips the divisions. One request is worked at a time. A
// finished result moves into the output register; if that register still holds
// an untaken result, the finished one waits and the next request is stalled.
// i_cfg_wdata sets the clock frequency in hertz (reset 72 MHz).
module uart_fractional_baud_search_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [28:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [21:0] wanted_baud
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [22:0] divisor, [30:23] frac_div
);
    logic [ufbs_pkg::ClkW-1:0] r_clk_hz;
    ufbs_pkg::t_cmd cmd;
    ufbs_pkg::t_sts sts;
    logic [ufbs_pkg::DivW-1:0]  divisor;
    logic [ufbs_pkg::FracW-1:0] frac;

    // Hold the clock frequency register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= ufbs_pkg::ClkReset;
        end else if (i_cfg_we) begin
            r_clk_hz <= i_cfg_wdata;
        end
    end

    ufbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ufbs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clk_hz    (r_clk_hz),
        .i_baud      (s_axis_tdata[21:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_divisor   (divisor),
        .o_frac      (frac)
    );

    assign m_axis_tdata = {1'b0, frac, divisor};

    // A waiting result stays valid and unchanged.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed while waiting");
    // A zero divisor always carries the default fraction.
    a_zero_div_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && divisor == '0) |-> (frac == ufbs_pkg::FracDefault))
        else $error("zero divisor with fraction");
    // An accepted request leaves ready low next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready stuck");
endmodule
`default_nettype wire

// File: rtl/ufbs_divider.sv
// Restoring bit-serial divider: 29-bit clock count over a 30-bit divisor.
`default_nettype none
module ufbs_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ufbs_pkg::ClkW-1:0]  i_dividend,
    input  wire logic [ufbs_pkg::QuoW:0]    i_divisor,
    output logic                            o_busy,
    output logic [ufbs_pkg::QuoW-1:0]       o_quotient,
    output logic                            o_rem_zero
);
    logic [ufbs_pkg::QuoW-1:0] r_quo, n_quo;
    logic [ufbs_pkg::QuoW:0]   r_rem, n_rem;
    logic [ufbs_pkg::QuoW:0]   r_dvs;
    logic [4:0]                r_cnt;
    logic                      r_busy;
    logic [ufbs_pkg::QuoW+1:0] trial;

    // One quotient bit per cycle.
    always_comb begin
        trial = {r_rem, r_quo[ufbs_pkg::QuoW-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = (ufbs_pkg::QuoW+1)'(trial - {1'b0, r_dvs});
            n_quo = {r_quo[ufbs_pkg::QuoW-2:0], 1'b1};
        end else begin
            n_rem = trial[ufbs_pkg::QuoW:0];
            n_quo = {r_quo[ufbs_pkg::QuoW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(ufbs_pkg::QuoW - 1);
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
    assign o_rem_zero = (r_rem == '0);
endmodule
`default_nettype wire

// File: rtl/ufbs_datapath.sv
// Datapath: operand registers, divider, products, table scan and output register.
`default_nettype none
module ufbs_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ufbs_pkg::ClkW-1:0]   i_clk_hz,
    input  wire logic [ufbs_pkg::BaudW-1:0]  i_baud,
    input  wire ufbs_pkg::t_cmd              i_cmd,
    output ufbs_pkg::t_sts                   o_sts,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [ufbs_pkg::DivW-1:0]        o_divisor,
    output logic [ufbs_pkg::FracW-1:0]       o_frac
);
    logic [ufbs_pkg::BaudW-1:0]  r_baud;
    logic [ufbs_pkg::QuoW-1:0]   r_quo96;
    logic [ufbs_pkg::DivW-1:0]   r_div;
    logic [ufbs_pkg::DenW-1:0]   r_den;
    logic [ufbs_pkg::ProdW-1:0]  r_lo, r_hi;
    logic [ufbs_pkg::ProdW-1:0]  r_num;
    logic [ufbs_pkg::FracW-1:0]  r_frac;
    logic [ufbs_pkg::IdxW-1:0]   r_idx;
    logic                        hit;
    logic                        r_ov;
    logic [ufbs_pkg::DivW-1:0]   r_out_div;
    logic [ufbs_pkg::FracW-1:0]  r_out_frac;
    logic [ufbs_pkg::QuoW:0]     dvs;
    logic                        dbusy, drz;
    logic [ufbs_pkg::QuoW-1:0]   dquo;
    logic [18:0]                 ent;
    logic [ufbs_pkg::ProdW-1:0]  prod;

    // Divisor is 64 or 96 times baud.
    always_comb begin
        if (i_cmd.dsel == ufbs_pkg::DSEL_64) begin
            dvs = {2'b0, r_baud, 6'd0};
        end else begin
            dvs = {2'b0, r_baud, 6'd0} + {3'b0, r_baud, 5'd0};
        end
    end

    ufbs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_clk_hz),
        .i_divisor  (dvs),
        .o_busy     (dbusy),
        .o_quotient (dquo),
        .o_rem_zero (drz)
    );

    assign ent  = ufbs_pkg::frac_entry(r_idx);
    assign prod = ufbs_pkg::ProdW'(ent[18:8]) * ufbs_pkg::ProdW'(r_den);

    // Capture operands, products and the scan result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_baud <= i_baud;
            r_num  <= ufbs_pkg::ProdW'(i_clk_hz) * ufbs_pkg::ProdW'(10'd1000);
            r_div  <= '0;
            r_frac <= ufbs_pkg::FracDefault;
        end
        if (i_cmd.save64) begin
            r_div <= ufbs_pkg::DivW'(dquo);
        end
        if (i_cmd.save96) begin
            r_quo96 <= dquo;
            r_div   <= ufbs_pkg::DivW'(dquo);
        end
        if (i_cmd.mk_den) begin
            r_den <= ufbs_pkg::DenW'({r_baud, 6'd0}) * ufbs_pkg::DenW'(r_quo96);
        end
        if (i_cmd.mul_lo) begin
            r_lo <= ufbs_pkg::ProdW'(ufbs_pkg::MilliLow) * ufbs_pkg::ProdW'(r_den);
        end
        if (i_cmd.mul_hi) begin
            r_hi <= ufbs_pkg::ProdW'(ufbs_pkg::MilliHigh) * ufbs_pkg::ProdW'(r_den);
        end
        if (i_cmd.scan_clr) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            if (prod > r_num) begin
                r_frac <= {ent[3:0], ent[7:4]};
            end
            r_idx <= r_idx + 7'd1;
        end
    end

    // Hold the result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_push) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Load the output register from the finished working values.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_push) begin
            r_out_div  <= r_div;
            r_out_frac <= r_frac;
        end
    end

    assign hit = (prod > r_num);

    assign o_sts.baud_zero = (r_baud == '0);
    assign o_sts.div_busy  = dbusy;
    assign o_sts.rem_zero  = drz;
    assign o_sts.quo_zero  = (dquo == '0);
    assign o_sts.in_range  = (r_num > r_lo) && (r_num < r_hi);
    assign o_sts.scan_hit  = hit;
    assign o_sts.scan_end  = (r_idx == 7'(ufbs_pkg::TableEntries - 1));
    assign o_out_valid = r_ov;
    assign o_divisor   = r_out_div;
    assign o_frac      = r_out_frac;
endmodule
`default_nettype wire

// File: rtl/ufbs_ctrl.sv
// Controller state machine sequencing the divisions, compares and table scan.
`default_nettype none
module ufbs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_out_valid,
    input  wire ufbs_pkg::t_sts i_sts,
    output ufbs_pkg::t_cmd      o_cmd
);
    ufbs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ufbs_pkg::S_IDLE:  if (i_in_valid) n_state = ufbs_pkg::S_DIV64;
            ufbs_pkg::S_DIV64: n_state = i_sts.baud_zero ? ufbs_pkg::S_DONE : ufbs_pkg::S_CHK64;
            ufbs_pkg::S_CHK64: begin
                if (!i_sts.div_busy) begin
                    n_state = i_sts.rem_zero ? ufbs_pkg::S_DONE : ufbs_pkg::S_DIV96;
                end
            end
            ufbs_pkg::S_DIV96: n_state = ufbs_pkg::S_CHK96;
            ufbs_pkg::S_CHK96: begin
                if (!i_sts.div_busy) begin
                    n_state = i_sts.quo_zero ? ufbs_pkg::S_DONE : ufbs_pkg::S_MULLO;
                end
            end
            ufbs_pkg::S_MULLO: n_state = ufbs_pkg::S_MULHI;
            ufbs_pkg::S_MULHI: n_state = ufbs_pkg::S_CMP;
            ufbs_pkg::S_CMP:   n_state = i_sts.in_range ? ufbs_pkg::S_SCAN : ufbs_pkg::S_DONE;
            ufbs_pkg::S_SCAN:  if (i_sts.scan_hit || i_sts.scan_end) n_state = ufbs_pkg::S_DONE;
            ufbs_pkg::S_DONE:  if (!i_out_valid) n_state = ufbs_pkg::S_IDLE;
            default:           n_state = ufbs_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_cmd.dsel = ufbs_pkg::DSEL_64;
        o_in_ready = 1'b0;
        case (r_state)
            ufbs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ufbs_pkg::S_DIV64: o_cmd.div_start = !i_sts.baud_zero;
            ufbs_pkg::S_CHK64: o_cmd.save64 = !i_sts.div_busy && i_sts.rem_zero;
            ufbs_pkg::S_DIV96: begin
                o_cmd.dsel      = ufbs_pkg::DSEL_96;
                o_cmd.div_start = 1'b1;
            end
            ufbs_pkg::S_CHK96: begin
                o_cmd.dsel   = ufbs_pkg::DSEL_96;
                o_cmd.save96 = !i_sts.div_busy;
            end
            ufbs_pkg::S_MULLO: o_cmd.mk_den = 1'b1;
            ufbs_pkg::S_MULHI: begin
                o_cmd.mul_lo = 1'b1;
                o_cmd.mul_hi = 1'b1;
            end
            ufbs_pkg::S_CMP:  o_cmd.scan_clr = 1'b1;
            ufbs_pkg::S_SCAN: o_cmd.scan_step = 1'b1;
            ufbs_pkg::S_DONE: o_cmd.out_push = !i_out_valid;
            default: ;
        endcase
    end
endmodule
`default_nettype wire
